// ----- src/kts_pkg.sv -----
// shared constants and types for the topological sort unit
`timescale 1ns / 1ps

package kts_pkg;

    localparam int KTS_NODE_LIMIT_DEF   = 64;
    localparam int KTS_FANOUT_LIMIT_DEF = 8;

    localparam int KTS_OPCODE_W = 2;
    localparam int KTS_IDX_W    = 6;
    localparam int KTS_COUNT_W  = 7;
    localparam int KTS_KIND_W   = 2;

    typedef enum logic [KTS_OPCODE_W-1:0] {
        OP_CLEAR    = 2'd0,
        OP_ADD_EDGE = 2'd1,
        OP_RUN      = 2'd2,
        OP_NOP      = 2'd3
    } t_opcode;

    typedef enum logic [KTS_KIND_W-1:0] {
        KIND_STATUS = 2'd0,
        KIND_ORDER  = 2'd1,
        KIND_EMPTY  = 2'd2
    } t_kind;

endpackage

// ----- src/kts_ifs.sv -----
// valid/ready channel interfaces for command words and result words
`timescale 1ns / 1ps

interface kts_in_if import kts_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [KTS_OPCODE_W-1:0] opcode;
    logic [KTS_IDX_W-1:0]    edge_source;
    logic [KTS_IDX_W-1:0]    edge_target;

    modport source (output valid, output opcode, output edge_source, output edge_target,
                    input ready);
    modport sink   (input valid, input opcode, input edge_source, input edge_target,
                    output ready);
endinterface

interface kts_out_if import kts_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [KTS_KIND_W-1:0]  kind;
    logic [KTS_IDX_W-1:0]   node_index;
    logic                   edge_accepted;
    logic [KTS_COUNT_W-1:0] sorted_count;
    logic                   cycle_found;
    logic                   last;

    modport source (output valid, output kind, output node_index, output edge_accepted,
                    output sorted_count, output cycle_found, output last, input ready);
    modport sink   (input valid, input kind, input node_index, input edge_accepted,
                    input sorted_count, input cycle_found, input last, output ready);
endinterface

// ----- src/kahn_topological_sort_unit.sv -----
// Kahn topological sort unit: graph store and sort sequencer
//
// Command words arrive on i_item (valid/ready) and result words leave on o_result
// (valid/ready). The graph size is written through i_cfg_we / i_cfg_wdata while idle.
// One command word is taken at a time; i_item.ready is high only while the
// sequencer is idle. Result words go through an output register, so the next
// command is taken while the last result still waits.
// Clear: a sweep over NODE_LIMIT entries, then one status word.
// Add edge: one status word; unused opcode: one status word.
// Run: load the working in-degree of each node, then pop each ready node and
// walk its stored successors, all through the single read port of each graph
// memory; one order word per emitted node, the last one carrying the count and
// cycle flag, or one empty-run word.
// After reset the counts and in-degrees are swept to zero over all NODE_LIMIT
// entries while i_item.ready stays low. A stalled receiver holds the sequencer
// at its next result word; nothing is dropped.
`timescale 1ns / 1ps

module kahn_topological_sort_unit import kts_pkg::*; #(
    parameter int NODE_LIMIT   = KTS_NODE_LIMIT_DEF,
    parameter int FANOUT_LIMIT = KTS_FANOUT_LIMIT_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [KTS_COUNT_W-1:0] i_cfg_wdata,
    kts_in_if.sink                 i_item,
    kts_out_if.source              o_result
);

    localparam int NW   = $clog2(NODE_LIMIT);
    localparam int CW   = $clog2(NODE_LIMIT + 1);
    localparam int CMPW = (CW > KTS_COUNT_W) ? CW : KTS_COUNT_W;
    localparam int KW   = $clog2(FANOUT_LIMIT + 1);
    localparam int LD   = NODE_LIMIT * FANOUT_LIMIT;
    localparam int LAW  = $clog2(LD);
    localparam int DW   = $clog2(LD + 1);

    typedef enum logic [3:0] {
        S_CLR,
        S_IDLE,
        S_ADD_RD,
        S_ADD_WR,
        S_STATUS,
        S_INIT_RD,
        S_INIT_WR,
        S_POP_RD,
        S_POP_DATA,
        S_CNT,
        S_EDGE_RD,
        S_EDGE_V,
        S_EDGE_W,
        S_FINISH
    } t_state;

    t_state                 r_state;
    logic [KTS_COUNT_W-1:0] r_graph_size;
    logic [NW-1:0]          r_idx;
    logic                   r_clr_report;
    logic [KTS_IDX_W-1:0]   r_src;
    logic [KTS_IDX_W-1:0]   r_dst;
    logic                   r_acc;
    logic [NW-1:0]          r_head;
    logic [NW-1:0]          r_tail;
    logic [CW-1:0]          r_fill;
    logic [CW-1:0]          r_emitted;
    logic                   r_pend_valid;
    logic [NW-1:0]          r_pend_node;
    logic [NW-1:0]          r_node;
    logic [NW-1:0]          r_v;
    logic [KW-1:0]          r_cnt;
    logic [KW-1:0]          r_e;

    logic                   r_out_valid;
    t_kind                  r_out_kind;
    logic [KTS_IDX_W-1:0]   r_out_node;
    logic                   r_out_acc;
    logic [KTS_COUNT_W-1:0] r_out_count;
    logic                   r_out_cycle;
    logic                   r_out_last;

    // ram ports
    logic           cnt_we;
    logic [NW-1:0]  cnt_waddr;
    logic [KW-1:0]  cnt_wdata;
    logic [NW-1:0]  cnt_raddr;
    logic [KW-1:0]  cnt_rdata;
    logic           deg_we;
    logic [NW-1:0]  deg_waddr;
    logic [DW-1:0]  deg_wdata;
    logic [NW-1:0]  deg_raddr;
    logic [DW-1:0]  deg_rdata;
    logic           lst_we;
    logic [LAW-1:0] lst_waddr;
    logic [NW-1:0]  lst_rdata;
    logic [LAW-1:0] lst_raddr;
    logic           wrk_we;
    logic [NW-1:0]  wrk_waddr;
    logic [DW-1:0]  wrk_wdata;
    logic [NW-1:0]  wrk_raddr;
    logic [DW-1:0]  wrk_rdata;
    logic           ff_we;
    logic [NW-1:0]  ff_wdata;
    logic [NW-1:0]  ff_rdata;

    logic [CMPW-1:0] live_n;
    logic            out_free;
    logic            out_load;
    logic            add_ok;
    logic            edge_in_range;
    logic            work_nonzero;
    logic            work_hits_zero;
    logic            init_zero;
    logic            init_done;

    assign live_n = (CMPW'(r_graph_size) > CMPW'(NODE_LIMIT)) ? CMPW'(NODE_LIMIT)
                                                              : CMPW'(r_graph_size);
    assign out_free = !r_out_valid || o_result.ready;
    assign add_ok = (CMPW'(r_src) < live_n) && (CMPW'(r_dst) < live_n)
                    && (cnt_rdata < KW'(FANOUT_LIMIT));
    assign edge_in_range  = CMPW'(lst_rdata) < live_n;
    assign work_nonzero   = wrk_rdata != '0;
    assign work_hits_zero = wrk_rdata == DW'(1);
    assign init_zero      = deg_rdata == '0;
    assign init_done      = (CMPW'(r_idx) + CMPW'(1)) == live_n;

    always_comb begin
        cnt_we    = 1'b0;
        cnt_waddr = NW'(r_src);
        cnt_wdata = '0;
        cnt_raddr = NW'(r_src);
        deg_we    = 1'b0;
        deg_waddr = NW'(r_dst);
        deg_wdata = '0;
        deg_raddr = NW'(r_dst);
        lst_we    = 1'b0;
        lst_waddr = LAW'(NW'(r_src)) * LAW'(FANOUT_LIMIT) + LAW'(cnt_rdata);
        lst_raddr = LAW'(r_node) * LAW'(FANOUT_LIMIT) + LAW'(r_e);
        wrk_we    = 1'b0;
        wrk_waddr = r_v;
        wrk_wdata = wrk_rdata - DW'(1);
        wrk_raddr = lst_rdata;
        ff_we     = 1'b0;
        ff_wdata  = r_v;
        out_load  = 1'b0;
        case (r_state)
            S_CLR: begin
                cnt_we    = 1'b1;
                cnt_waddr = r_idx;
                deg_we    = 1'b1;
                deg_waddr = r_idx;
            end
            S_ADD_WR: begin
                if (add_ok) begin
                    lst_we    = 1'b1;
                    cnt_we    = 1'b1;
                    cnt_wdata = cnt_rdata + KW'(1);
                    deg_we    = 1'b1;
                    deg_wdata = deg_rdata + DW'(1);
                end
            end
            S_STATUS: begin
                out_load = out_free;
            end
            S_INIT_RD: begin
                deg_raddr = r_idx;
            end
            S_INIT_WR: begin
                wrk_we    = 1'b1;
                wrk_waddr = r_idx;
                wrk_wdata = deg_rdata;
                ff_we     = init_zero;
                ff_wdata  = r_idx;
            end
            S_POP_RD: begin
                out_load = (r_fill != '0) && r_pend_valid && out_free;
            end
            S_POP_DATA: begin
                cnt_raddr = ff_rdata;
            end
            S_EDGE_W: begin
                wrk_we = work_nonzero;
                ff_we  = work_nonzero && work_hits_zero;
            end
            S_FINISH: begin
                out_load = out_free;
            end
            default: begin
            end
        endcase
    end

    kts_ram #(.WIDTH(KW), .DEPTH(NODE_LIMIT)) u_succ_count (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (cnt_waddr),
        .i_wdata (cnt_wdata),
        .i_raddr (cnt_raddr),
        .o_rdata (cnt_rdata)
    );

    kts_ram #(.WIDTH(DW), .DEPTH(NODE_LIMIT)) u_indegree (
        .i_clk   (i_clk),
        .i_we    (deg_we),
        .i_waddr (deg_waddr),
        .i_wdata (deg_wdata),
        .i_raddr (deg_raddr),
        .o_rdata (deg_rdata)
    );

    kts_ram #(.WIDTH(NW), .DEPTH(LD)) u_succ_list (
        .i_clk   (i_clk),
        .i_we    (lst_we),
        .i_waddr (lst_waddr),
        .i_wdata (NW'(r_dst)),
        .i_raddr (lst_raddr),
        .o_rdata (lst_rdata)
    );

    kts_ram #(.WIDTH(DW), .DEPTH(NODE_LIMIT)) u_work_deg (
        .i_clk   (i_clk),
        .i_we    (wrk_we),
        .i_waddr (wrk_waddr),
        .i_wdata (wrk_wdata),
        .i_raddr (wrk_raddr),
        .o_rdata (wrk_rdata)
    );

    kts_ram #(.WIDTH(NW), .DEPTH(NODE_LIMIT)) u_ready_fifo (
        .i_clk   (i_clk),
        .i_we    (ff_we),
        .i_waddr (r_tail),
        .i_wdata (ff_wdata),
        .i_raddr (r_head),
        .o_rdata (ff_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLR;
            r_graph_size <= '0;
            r_idx        <= '0;
            r_clr_report <= 1'b0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
            r_head       <= '0;
            r_tail       <= '0;
            r_fill       <= '0;
            r_emitted    <= '0;
        end else begin
            if (i_cfg_we) begin
                r_graph_size <= i_cfg_wdata;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
            if (ff_we) begin
                r_tail <= r_tail + NW'(1);
                r_fill <= r_fill + CW'(1);
            end
            case (r_state)
                S_CLR: begin
                    r_idx <= r_idx + NW'(1);
                    if (r_idx == NW'(NODE_LIMIT - 1)) begin
                        r_acc   <= 1'b1;
                        r_state <= r_clr_report ? S_STATUS : S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_item.valid) begin
                        r_src <= i_item.edge_source;
                        r_dst <= i_item.edge_target;
                        case (t_opcode'(i_item.opcode))
                            OP_CLEAR: begin
                                r_idx        <= '0;
                                r_clr_report <= 1'b1;
                                r_state      <= S_CLR;
                            end
                            OP_ADD_EDGE: begin
                                r_state <= S_ADD_RD;
                            end
                            OP_RUN: begin
                                r_idx        <= '0;
                                r_head       <= '0;
                                r_tail       <= '0;
                                r_fill       <= '0;
                                r_emitted    <= '0;
                                r_pend_valid <= 1'b0;
                                r_state      <= (live_n == '0) ? S_FINISH : S_INIT_RD;
                            end
                            default: begin
                                r_acc   <= 1'b0;
                                r_state <= S_STATUS;
                            end
                        endcase
                    end
                end
                S_ADD_RD: begin
                    r_state <= S_ADD_WR;
                end
                S_ADD_WR: begin
                    r_acc   <= add_ok;
                    r_state <= S_STATUS;
                end
                S_STATUS: begin
                    if (out_free) begin
                        r_out_kind  <= KIND_STATUS;
                        r_out_node  <= '0;
                        r_out_acc   <= r_acc;
                        r_out_count <= '0;
                        r_out_cycle <= 1'b0;
                        r_out_last  <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                S_INIT_RD: begin
                    r_state <= S_INIT_WR;
                end
                S_INIT_WR: begin
                    r_idx   <= r_idx + NW'(1);
                    r_state <= init_done ? S_POP_RD : S_INIT_RD;
                end
                S_POP_RD: begin
                    if (r_fill == '0) begin
                        r_state <= S_FINISH;
                    end else if (r_pend_valid) begin
                        if (out_free) begin
                            r_out_kind   <= KIND_ORDER;
                            r_out_node   <= KTS_IDX_W'(r_pend_node);
                            r_out_acc    <= 1'b0;
                            r_out_count  <= '0;
                            r_out_cycle  <= 1'b0;
                            r_out_last   <= 1'b0;
                            r_pend_valid <= 1'b0;
                        end
                    end else begin
                        r_head  <= r_head + NW'(1);
                        r_fill  <= r_fill - CW'(1);
                        r_state <= S_POP_DATA;
                    end
                end
                S_POP_DATA: begin
                    r_node       <= ff_rdata;
                    r_pend_node  <= ff_rdata;
                    r_pend_valid <= 1'b1;
                    r_emitted    <= r_emitted + CW'(1);
                    r_state      <= S_CNT;
                end
                S_CNT: begin
                    r_cnt   <= cnt_rdata;
                    r_e     <= '0;
                    r_state <= S_EDGE_RD;
                end
                S_EDGE_RD: begin
                    r_state <= (r_e == r_cnt) ? S_POP_RD : S_EDGE_V;
                end
                S_EDGE_V: begin
                    r_v <= lst_rdata;
                    if (edge_in_range) begin
                        r_state <= S_EDGE_W;
                    end else begin
                        r_e     <= r_e + KW'(1);
                        r_state <= S_EDGE_RD;
                    end
                end
                S_EDGE_W: begin
                    r_e     <= r_e + KW'(1);
                    r_state <= S_EDGE_RD;
                end
                S_FINISH: begin
                    if (out_free) begin
                        r_out_acc   <= 1'b0;
                        r_out_last  <= 1'b1;
                        if (r_pend_valid) begin
                            r_out_kind   <= KIND_ORDER;
                            r_out_node   <= KTS_IDX_W'(r_pend_node);
                            r_out_count  <= KTS_COUNT_W'(r_emitted);
                            r_out_cycle  <= CMPW'(r_emitted) < live_n;
                            r_pend_valid <= 1'b0;
                        end else begin
                            r_out_kind  <= KIND_EMPTY;
                            r_out_node  <= '0;
                            r_out_count <= '0;
                            r_out_cycle <= live_n != '0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_item.ready           = r_state == S_IDLE;
    assign o_result.valid         = r_out_valid;
    assign o_result.kind          = r_out_kind;
    assign o_result.node_index    = r_out_node;
    assign o_result.edge_accepted = r_out_acc;
    assign o_result.sorted_count  = r_out_count;
    assign o_result.cycle_found   = r_out_cycle;
    assign o_result.last          = r_out_last;

endmodule

// ----- src/kts_ram.sv -----
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module kts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
